>>> design/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
// Port widths, parameter defaults and command codes; no dependencies.
package mexp_pkg;

    // widths of the item fields on the ports
    localparam int unsigned MOD_FIELD_W = 32;
    localparam int unsigned EXP_FIELD_W = 64;

    // parameter defaults for the top level
    localparam int unsigned MOD_WIDTH_DEF = 32;
    localparam int unsigned EXP_WIDTH_DEF = 64;

    // command codes
    localparam logic CMD_POWER   = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

endpackage

>>> design/mexp_mulmod.sv
// Shared modular multiplier: one registered product, then bit-serial
// restoring reduction, one product bit per cycle. No package dependency.
module mexp_mulmod #(
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MOD_WIDTH-1:0] a,
    input  logic [MOD_WIDTH-1:0] b,
    input  logic [MOD_WIDTH-1:0] m,
    output logic                 done,
    output logic [MOD_WIDTH-1:0] result
);

    localparam int unsigned P_W   = 2 * MOD_WIDTH;
    localparam int unsigned CNT_W = $clog2(P_W);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MULT = 3'b010,
        PH_RED  = 3'b100
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [MOD_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;
    logic [P_W-1:0]       prod_reg, prod_next;
    logic [MOD_WIDTH-1:0] rem_reg, rem_next;

    // one restoring step: bring in the next product bit, subtract if it fits
    logic [MOD_WIDTH:0]   trial;
    logic [MOD_WIDTH:0]   trial_sub;

    assign trial     = {rem_reg, prod_reg[P_W-1]};
    assign trial_sub = trial - {1'b0, m_reg};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    m_next     = m;
                    phase_next = PH_MULT;
                end
            end
            PH_MULT:
            begin
                prod_next  = P_W'(a_reg) * P_W'(b_reg);
                rem_next   = '0;
                cnt_next   = '0;
                phase_next = PH_RED;
            end
            PH_RED:
            begin
                if (trial >= {1'b0, m_reg})
                begin
                    rem_next = trial_sub[MOD_WIDTH-1:0];
                end
                else
                begin
                    rem_next = trial[MOD_WIDTH-1:0];
                end
                prod_next = {prod_reg[P_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(P_W - 1))
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

>>> design/modular_exponentiation_unit.sv
// Top level of the modular exponentiation block: square-and-multiply sequencer.
// Depends on mexp_pkg and mexp_mulmod.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+-----------
//  in      | in_valid, in_stall, command, base, exponent, | item in
//          | modulus                                      |
//  out     | out_valid, out_stall, power_result,          | item out
//          | bad_modulus                                  |
//
// A set exponent bit needs two products in the shared unit, the square issued as the
// multiply ends; a clear bit needs only the square. A zero modulus or zero exponent
// skips the multiplier: acceptance goes straight to S_DONE, which loads the output.
// Reset clears the sequencer, the multiplier and the output valid. in_stall is high
// until the result is loaded; a result held by out_stall does not block the next item.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF,
    parameter int unsigned EXP_WIDTH = EXP_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [MOD_FIELD_W-1:0] base,
    input  logic [EXP_FIELD_W-1:0] exponent,
    input  logic [MOD_FIELD_W-1:0] modulus,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MOD_FIELD_W-1:0] power_result,
    output logic                   bad_modulus
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_STEP     = 6'b000010,
        S_WAIT_ACC = 6'b000100,
        S_WAIT_SQR = 6'b001000,
        S_DONE     = 6'b010000,
        S_SPARE    = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] m_reg, m_next;
    logic [EXP_WIDTH-1:0] e_reg, e_next;
    logic                 bad_reg, bad_next;

    logic                   out_valid_reg, out_valid_next;
    logic [MOD_FIELD_W-1:0] power_result_reg, power_result_next;
    logic                   bad_modulus_reg, bad_modulus_next;

    // operand selection for the shared multiplier
    logic                 mm_start;
    logic [MOD_WIDTH-1:0] mm_a;
    logic [MOD_WIDTH-1:0] mm_b;
    logic                 mm_done;
    logic [MOD_WIDTH-1:0] mm_result;

    // exponent as taken in; the inverse uses modulus - 2, wrapping in 64 bits
    logic [MOD_WIDTH-1:0]   mod_in;
    logic [EXP_FIELD_W-1:0] inv_exp;
    logic [EXP_WIDTH-1:0]   exp_in;

    assign mod_in  = modulus[MOD_WIDTH-1:0];
    assign inv_exp = EXP_FIELD_W'(mod_in) - EXP_FIELD_W'(2);
    assign exp_in  = (command == CMD_INVERSE) ? inv_exp[EXP_WIDTH-1:0]
                                              : exponent[EXP_WIDTH-1:0];

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        acc_next          = acc_reg;
        b_next            = b_reg;
        m_next            = m_reg;
        e_next            = e_reg;
        bad_next          = bad_reg;
        out_valid_next    = out_valid_reg;
        power_result_next = power_result_reg;
        bad_modulus_next  = bad_modulus_reg;
        mm_start          = 1'b0;
        mm_a              = acc_reg;
        mm_b              = b_reg;

        // the waiting result leaves when the far side takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    b_next   = base[MOD_WIDTH-1:0];
                    m_next   = mod_in;
                    e_next   = exp_in;
                    acc_next = MOD_WIDTH'(1);
                    bad_next = 1'b0;
                    if (mod_in == '0)
                    begin
                        // undefined modulus: flag it, result is zero
                        acc_next   = '0;
                        bad_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (exp_in == '0)
                    begin
                        // result stays 1, not reduced
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                mm_start = 1'b1;
                if (e_reg[0])
                begin
                    mm_a       = acc_reg;
                    state_next = S_WAIT_ACC;
                end
                else
                begin
                    mm_a       = b_reg;
                    state_next = S_WAIT_SQR;
                end
            end
            S_WAIT_ACC:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_result;
                    // square the old base next
                    mm_start   = 1'b1;
                    mm_a       = b_reg;
                    state_next = S_WAIT_SQR;
                end
            end
            S_WAIT_SQR:
            begin
                if (mm_done)
                begin
                    b_next = mm_result;
                    e_next = e_reg >> 1;
                    if (e_reg[EXP_WIDTH-1:1] == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    power_result_next = MOD_FIELD_W'(acc_reg);
                    bad_modulus_next  = bad_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        b_reg            <= b_next;
        m_reg            <= m_next;
        e_reg            <= e_next;
        bad_reg          <= bad_next;
        power_result_reg <= power_result_next;
        bad_modulus_reg  <= bad_modulus_next;
    end

    mexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (m_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;
    assign bad_modulus  = bad_modulus_reg;

endmodule
